[hdl/spde_pkg.sv]
// spde_pkg: shared types, constants and command/status structs for the
// shortest path distance engine; no dependencies
`timescale 1ns / 1ps

package spde_pkg;

  localparam int NodeLimit  = 1024;
  localparam int EdgeLimit  = 4096;
  localparam int WeightBits = 16;

  localparam int NodeBits   = $clog2(NodeLimit);      // node index width
  localparam int CountBits  = 11;                     // node_count register width
  localparam int EdgeBits   = $clog2(EdgeLimit);      // edge index width
  localparam int ETotBits   = EdgeBits + 1;           // edge count width
  localparam int DistBits   = 32;

  localparam logic [DistBits-1:0] DistMax = '1;

  localparam logic [1:0] OpAdd   = 2'd0;
  localparam logic [1:0] OpQuery = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StRange = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture the request
    logic edge_write;  // store captured edge
    logic edge_clear;  // empty the edge store
    logic init_clr;    // clear scratch entry at node counter
    logic init_done;   // seed source after clearing
    logic scan_step;   // look at one node in the min scan
    logic scan_start;  // reset scan
    logic settle;      // mark chosen node settled
    logic relax_step;  // process one edge
    logic relax_start; // reset edge counter
    logic rd_target;   // read target's distance
    logic res_query;   // build query result
    logic res_plain;   // build add/clear/other result
  } spde_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_add;
    logic is_query;
    logic is_clear;
    logic in_range;
    logic store_full;
    logic init_last;
    logic scan_last;
    logic found;
    logic relax_last;
    logic relax_idle;  // no edges to walk
    logic pipe_busy;   // relax pipeline still holds writes
  } spde_stat_t;

endpackage

[hdl/spde_ctrl.sv]
// spde_ctrl: sequencer for edge loading and the scan-based search
// depends on spde_pkg
`timescale 1ns / 1ps

module spde_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_fire,
  input  logic                  res_free,
  input  spde_pkg::spde_stat_t  stat,
  output spde_pkg::spde_cmd_t   cmd,
  output logic                  idle,
  output logic                  res_load
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_INIT   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_PICK   = 4'd4;
  localparam logic [3:0] S_RELAX  = 4'd5;
  localparam logic [3:0] S_DRAIN  = 4'd6;
  localparam logic [3:0] S_RD     = 4'd7;
  localparam logic [3:0] S_RD2    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    res_load  = 1'b0;
    idle      = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (req_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.is_query && stat.in_range) begin
          cmd.init_clr = 1'b1;
          state_nxt    = stat.init_last ? S_SCAN : S_INIT;
          if (stat.init_last) begin
            cmd.init_done  = 1'b1;
            cmd.scan_start = 1'b1;
          end
        end else begin
          cmd.edge_write = stat.is_add && stat.in_range && !stat.store_full;
          cmd.edge_clear = stat.is_clear;
          cmd.res_plain  = 1'b1;
          state_nxt      = S_OUT;
        end
      end
      S_INIT: begin
        cmd.init_clr = 1'b1;
        if (stat.init_last) begin
          cmd.init_done  = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_nxt = S_PICK;
      end
      S_PICK: begin
        if (stat.found) begin
          cmd.settle      = 1'b1;
          cmd.relax_start = 1'b1;
          state_nxt       = stat.relax_idle ? S_DRAIN : S_RELAX;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RELAX: begin
        cmd.relax_step = 1'b1;
        if (stat.relax_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_RD: begin
        cmd.rd_target = 1'b1;
        state_nxt     = S_RD2;
      end
      S_RD2: begin
        cmd.res_query = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (res_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

[hdl/spde_dpath.sv]
// spde_dpath: edge store, distance memory, settled marks, scan and relax units
// depends on spde_pkg
`timescale 1ns / 1ps

module spde_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spde_pkg::spde_cmd_t               cmd,
  output spde_pkg::spde_stat_t              stat,
  input  logic [1:0]                        in_op,
  input  logic [spde_pkg::NodeBits-1:0]     in_a,
  input  logic [spde_pkg::NodeBits-1:0]     in_b,
  input  logic [15:0]                       in_w,
  input  logic [spde_pkg::CountBits-1:0]    node_count,
  output logic [spde_pkg::DistBits-1:0]     res_distance,
  output logic                              res_reachable,
  output logic [1:0]                        res_status
);

  localparam int NB = spde_pkg::NodeBits;
  localparam int EB = spde_pkg::EdgeBits;
  localparam int DB = spde_pkg::DistBits;
  localparam int WB = spde_pkg::WeightBits;
  localparam int NL = spde_pkg::NodeLimit;
  localparam int EL = spde_pkg::EdgeLimit;

  // captured request
  logic [1:0]    op_r;
  logic [NB-1:0] a_r, b_r;
  logic [WB-1:0] w_r;
  logic [NB:0]   lim_r;

  logic [NB:0]   lim_now;
  assign lim_now = ({1'b0, node_count} < (spde_pkg::CountBits+1)'(NL)) ?
                   (NB+1)'(node_count) : (NB+1)'(NL);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      a_r   <= in_a;
      b_r   <= in_b;
      w_r   <= in_w[WB-1:0];
      lim_r <= lim_now;
    end
  end

  // edge store
  logic [2*NB+WB-1:0] edge_mem [EL];
  logic [EB:0]        etot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) etot_r <= '0;
    else if (cmd.edge_clear) etot_r <= '0;
    else if (cmd.edge_write) etot_r <= etot_r + 1'b1;
  end

  // node scratch: distance memory, reached and settled flags
  logic [DB-1:0] dist_mem [NL];
  logic          reach_mem [NL];
  logic          sett_mem  [NL];

  logic [NB:0]   ncnt_r;     // init and scan counter
  logic [DB-1:0] best_r;
  logic [NB-1:0] u_r;
  logic          found_r;
  logic [DB-1:0] u_dist_r;

  // scan read stage
  logic          sv_r;       // scan read pending
  logic [NB-1:0] sidx_r;
  logic [DB-1:0] sdist_r;
  logic          sreach_r, ssett_r;

  // relax pipeline: edge read, then node read, then write
  logic [EB:0]   ecnt_r;
  logic          p1_r;
  logic [2*NB+WB-1:0] edge_q;
  logic          p2_r;
  logic [NB-1:0] p2_to_r;
  logic [DB-1:0] p2_cand_r;
  logic          p3_r;
  logic [NB-1:0] p3_to_r;
  logic [DB-1:0] p3_cand_r;
  logic [DB-1:0] p3_old_r;
  logic          p3_reach_r;
  logic          w4_v_r;     // write done last cycle, not yet seen by the read
  logic [NB-1:0] w4_to_r;
  logic [DB-1:0] w4_cand_r;
  logic          p1b_r;      // second endpoint pending
  logic [NB-1:0] p1b_to_r;
  logic [DB-1:0] p1b_cand_r;

  logic [NB-1:0] ea, eb;
  logic [WB-1:0] ew;
  assign ea = edge_q[NB-1:0];
  assign eb = edge_q[2*NB-1:NB];
  assign ew = edge_q[2*NB+WB-1:2*NB];

  logic [DB:0]   sum;
  assign sum = {1'b0, u_dist_r} + (DB+1)'(ew);
  logic [DB-1:0] cand;
  assign cand = sum[DB] ? spde_pkg::DistMax : sum[DB-1:0];

  logic e_ok, hit_a, hit_b;
  assign e_ok  = ({1'b0, ea} < lim_r) && ({1'b0, eb} < lim_r);
  assign hit_a = p1_r && e_ok && (ea == u_r);
  assign hit_b = p1_r && e_ok && (eb == u_r);

  // one relax write port: a self-loop or double hit queues the second side
  logic          rq_v;
  logic [NB-1:0] rq_to;
  logic [DB-1:0] rq_cand;
  always_comb begin
    rq_v    = 1'b0;
    rq_to   = eb;
    rq_cand = cand;
    if (p1b_r) begin
      rq_v = 1'b1; rq_to = p1b_to_r; rq_cand = p1b_cand_r;
    end else if (hit_a) begin
      rq_v = 1'b1; rq_to = eb;
    end else if (hit_b) begin
      rq_v = 1'b1; rq_to = ea;
    end
  end

  // hold the edge stream while the second side goes out
  logic stall;
  assign stall = hit_a && hit_b && !p1b_r;

  logic relax_wr;
  assign relax_wr = p3_r && (!p3_reach_r || p3_cand_r < p3_old_r);

  // hazard: writes from the two stages ahead must be seen
  logic [DB-1:0] fwd_old;
  logic          fwd_reach;
  logic [DB-1:0] rd_dist;
  logic          rd_reach;

  // target read shares the relax read port
  logic [NB-1:0] rd_sel;
  assign rd_sel = cmd.rd_target ? b_r : rq_to;

  always_ff @(posedge clk) begin
    rd_dist  <= dist_mem[rd_sel];
    rd_reach <= reach_mem[rd_sel];
  end

  always_comb begin
    fwd_old   = rd_dist;
    fwd_reach = rd_reach;
    if (relax_wr && p3_to_r == p2_to_r) begin
      fwd_old   = p3_cand_r;
      fwd_reach = 1'b1;
    end else if (w4_v_r && w4_to_r == p2_to_r) begin
      fwd_old   = w4_cand_r;
      fwd_reach = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_write) edge_mem[etot_r[EB-1:0]] <= {w_r, b_r, a_r};
    edge_q <= edge_mem[ecnt_r[EB-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= 1'b0; p2_r <= 1'b0; p3_r <= 1'b0; p1b_r <= 1'b0; w4_v_r <= 1'b0;
    end else begin
      p1_r   <= cmd.relax_step && !stall;
      p2_r   <= rq_v;
      p3_r   <= p2_r;
      p1b_r  <= stall;
      w4_v_r <= relax_wr;
    end
    p1b_to_r   <= ea;
    p1b_cand_r <= cand;
    p2_to_r    <= rq_to;
    p2_cand_r  <= rq_cand;
    p3_to_r    <= p2_to_r;
    p3_cand_r  <= p2_cand_r;
    p3_old_r   <= fwd_old;
    p3_reach_r <= fwd_reach;
    w4_to_r    <= p3_to_r;
    w4_cand_r  <= p3_cand_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.relax_start)                ecnt_r <= '0;
    else if (cmd.relax_step && !stall)  ecnt_r <= ecnt_r + 1'b1;
  end

  // the seed write collides with the last clear; apply it in the next cycle
  logic seed_r;
  always_ff @(posedge clk) begin
    if (!rst_n) seed_r <= 1'b0;
    else        seed_r <= cmd.init_done;
  end

  // scratch writes; one port each
  logic [NB-1:0] cidx;
  assign cidx = ncnt_r[NB-1:0];

  always_ff @(posedge clk) begin
    if (cmd.init_clr) begin
      dist_mem[cidx]  <= '0;
      reach_mem[cidx] <= 1'b0;
    end else if (seed_r) begin
      dist_mem[a_r]  <= '0;
      reach_mem[a_r] <= 1'b1;
    end else if (relax_wr) begin
      dist_mem[p3_to_r]  <= p3_cand_r;
      reach_mem[p3_to_r] <= 1'b1;
    end
    if (cmd.init_clr)    sett_mem[cidx] <= 1'b0;
    else if (cmd.settle) sett_mem[u_r]  <= 1'b1;
  end

  // scan: one node per cycle, read registered, compare the next cycle
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.scan_start) ncnt_r <= '0;
    else if (cmd.init_clr || cmd.scan_step) ncnt_r <= ncnt_r + 1'b1;
    sidx_r   <= cidx;
    sdist_r  <= seed_r ? '0 : dist_mem[cidx];
    sreach_r <= (seed_r && cidx == a_r) ? 1'b1 : reach_mem[cidx];
    ssett_r  <= sett_mem[cidx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r <= 1'b0;
    else        sv_r <= cmd.scan_step && (ncnt_r < lim_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      found_r <= 1'b0;
    end else if (sv_r && sreach_r && !ssett_r && (!found_r || sdist_r < best_r)) begin
      found_r <= 1'b1;
      best_r  <= sdist_r;
      u_r     <= sidx_r;
    end
    if (cmd.settle) u_dist_r <= best_r;
  end

  // result
  always_ff @(posedge clk) begin
    if (cmd.res_plain) begin
      res_distance  <= '0;
      res_reachable <= 1'b0;
      if (op_r == spde_pkg::OpAdd || op_r == spde_pkg::OpQuery) begin
        res_status <= !stat.in_range ? spde_pkg::StRange :
                      stat.store_full ? spde_pkg::StFull : spde_pkg::StOk;
      end else begin
        res_status <= spde_pkg::StOk;
      end
    end else if (cmd.res_query) begin
      res_distance  <= rd_reach ? rd_dist : '0;
      res_reachable <= rd_reach;
      res_status    <= spde_pkg::StOk;
    end
  end

  always_comb begin
    stat            = '0;
    stat.is_add     = (op_r == spde_pkg::OpAdd);
    stat.is_query   = (op_r == spde_pkg::OpQuery);
    stat.is_clear   = (op_r == spde_pkg::OpClear);
    stat.in_range   = ({1'b0, a_r} < lim_r) && ({1'b0, b_r} < lim_r);
    stat.store_full = (etot_r >= (EB+1)'(EL));
    stat.init_last  = (ncnt_r == (NB+1)'(NL-1));
    stat.scan_last  = (ncnt_r >= lim_r) && !sv_r;
    stat.found      = found_r;
    stat.relax_idle = (etot_r == '0);
    stat.relax_last = !stall && (ecnt_r + 1'b1 >= etot_r);
    stat.pipe_busy  = p1_r || p2_r || p3_r || p1b_r;
  end

endmodule

[hdl/shortest_path_distance_engine.sv]
// shortest_path_distance_engine: top level, stream ports, config register
// depends on spde_pkg, spde_ctrl, spde_dpath
`timescale 1ns / 1ps

// usage
//   in_ channel: one request per item; tdata {weight, node_b, node_a, op}
//   out_ channel: one result per request; tdata {status, reachable, distance}
//   cfg_ port: apb-style, register 0 at address 0 is node_count (reset 1024)
// sequence
//   add, clear and unused ops: decode, then the result is moved into the
//   output register, and only then is a new request taken
//   query: the whole scratch memory is cleared, then per settled node a scan
//   of min(node_count, 1024) nodes, a pick and a walk over all stored edges
//   (with a pipeline drain, and a stall for each edge with both ends on the
//   settled node, set by the single-port node memory); a final scan, the
//   target read and the output state deliver the result
//   one request is in work at a time; in_tready is low until its result
//   has been moved into the output register
// reset
//   synchronous, active low; edge store emptied by its count, node_count
//   back to 1024, no result pending
// stall
//   the result holds in out_tdata while out_tready is low; the next request
//   is still taken, its result waiting for a free output register

module shortest_path_distance_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op[1:0], node_a[11:2], node_b[21:12], weight[37:22]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // distance[31:0], reachable[32], status[34:33]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [2:0] RegNodeCount = 3'd0;

  logic [spde_pkg::CountBits-1:0] node_count_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= spde_pkg::CountBits'(spde_pkg::NodeLimit);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == RegNodeCount) begin
      node_count_r <= cfg_pwdata[spde_pkg::CountBits-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == RegNodeCount) ?
                      {{(32-spde_pkg::CountBits){1'b0}}, node_count_r} : '0;

  spde_pkg::spde_cmd_t  cmd;
  spde_pkg::spde_stat_t stat;
  logic idle, res_load;
  logic req_fire;

  logic [spde_pkg::DistBits-1:0] res_distance;
  logic                          res_reachable;
  logic [1:0]                    res_status;

  // output register
  logic        ov_r;
  logic [34:0] od_r;

  assign in_tready = idle;
  assign req_fire  = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      if (res_load)                     ov_r <= 1'b1;
      else if (out_tvalid && out_tready) ov_r <= 1'b0;
    end
    if (res_load) od_r <= {res_status, res_reachable, res_distance};
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, od_r};

  spde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_fire (req_fire),
    .res_free (!ov_r || out_tready),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle),
    .res_load (res_load)
  );

  spde_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_op         (in_tdata[1:0]),
    .in_a          (in_tdata[11:2]),
    .in_b          (in_tdata[21:12]),
    .in_w          (in_tdata[37:22]),
    .node_count    (node_count_r),
    .res_distance  (res_distance),
    .res_reachable (res_reachable),
    .res_status    (res_status)
  );

  // a result is only loaded into a free output register
  assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!ov_r || out_tready))
    else $error("result overwrote a pending output");

  // no result loaded while an unsent result sits stalled in the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |-> !res_load)
    else $error("result loaded while output stalled");

  // a result flagged with a non-ok status never reports reachable
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[34:33] != spde_pkg::StOk) |-> !out_tdata[32])
    else $error("flagged result claims reachable");

endmodule

[verif/shortest_path_distance_engine_tb.sv]
// shortest_path_distance_engine_tb: self-checking testbench for the shortest
// path distance engine; depends on spde_pkg and shortest_path_distance_engine
`timescale 1ns / 1ps

module shortest_path_distance_engine_tb;

  localparam int CycleLimit = 30000000;

  // same bit order as out_tdata: distance in the low bits
  typedef struct packed {
    logic [1:0]  status;
    logic        reachable;
    logic [31:0] distance;
  } path_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  shortest_path_distance_engine dut (.*);

  always #5 clk = ~clk;

  // shadow copy of the engine's graph and register
  logic [10:0]                         node_cnt = 11'd1024;
  logic [spde_pkg::ETotBits-1:0]       edge_cnt = '0;
  logic [spde_pkg::NodeBits-1:0]       edge_u [spde_pkg::EdgeLimit];
  logic [spde_pkg::NodeBits-1:0]       edge_v [spde_pkg::EdgeLimit];
  logic [spde_pkg::WeightBits-1:0]     edge_wt [spde_pkg::EdgeLimit];

  logic [39:0]  request_queue [$];
  path_result_t expected_results [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int reach_seen = 0;
  longint cycles = 0;

  function automatic logic [39:0] pack_req(logic [1:0] op, int a, int b, int w);
    return {2'b00, w[15:0], b[9:0], a[9:0], op};
  endfunction

  // dijkstra by linear min scan over the shadow store, ties to the lowest node
  function automatic path_result_t predict_result(logic [39:0] d);
    logic [1:0]  op;
    int          a, b, w, lim, u, e;
    bit          found;
    logic [31:0] best [spde_pkg::NodeLimit];
    bit          done [spde_pkg::NodeLimit];
    bit          seen [spde_pkg::NodeLimit];
    logic [32:0] s;
    logic [31:0] cand;
    int          other;
    path_result_t r;
    op = d[1:0];
    a = int'(d[11:2]);
    b = int'(d[21:12]);
    w = int'(d[37:22]);
    lim = (int'(node_cnt) < spde_pkg::NodeLimit) ? int'(node_cnt) : spde_pkg::NodeLimit;
    r = '0;
    r.status = spde_pkg::StOk;
    if (op == spde_pkg::OpAdd) begin
      if (a >= lim || b >= lim) begin
        r.status = spde_pkg::StRange;
      end else if (edge_cnt >= spde_pkg::EdgeLimit) begin
        r.status = spde_pkg::StFull;
      end else begin
        edge_u[edge_cnt] = a[9:0];
        edge_v[edge_cnt] = b[9:0];
        edge_wt[edge_cnt] = w[15:0];
        edge_cnt++;
      end
    end else if (op == spde_pkg::OpQuery) begin
      if (a >= lim || b >= lim) begin
        r.status = spde_pkg::StRange;
      end else begin
        for (int i = 0; i < spde_pkg::NodeLimit; i++) begin
          best[i] = '0;
          done[i] = 0;
          seen[i] = 0;
        end
        seen[a] = 1;
        forever begin
          found = 0;
          u = 0;
          for (int i = 0; i < lim; i++)
            if (seen[i] && !done[i] && (!found || best[i] < best[u])) begin
              u = i;
              found = 1;
            end
          if (!found) break;
          done[u] = 1;
          for (e = 0; e < int'(edge_cnt); e++) begin
            if (edge_u[e] >= lim || edge_v[e] >= lim) continue;
            s = {1'b0, best[u]} + 33'(edge_wt[e]);
            cand = s[32] ? spde_pkg::DistMax : s[31:0];
            for (int k = 0; k < 2; k++) begin
              // an edge touches u on one or both ends
              if ((k == 0 ? edge_u[e] : edge_v[e]) != u) continue;
              other = (k == 0) ? int'(edge_v[e]) : int'(edge_u[e]);
              if (!seen[other] || cand < best[other]) begin
                seen[other] = 1;
                best[other] = cand;
              end
            end
          end
        end
        if (seen[b]) begin
          r.reachable = 1'b1;
          r.distance = best[b];
        end
      end
    end else if (op == spde_pkg::OpClear) begin
      edge_cnt = '0;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // sender: presents the next request, prediction taken at acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.insert(expected_results.size(), predict_result(in_tdata));
        requests_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata <= request_queue.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random backpressure and in-order checking of results
  always @(posedge clk) begin
    path_result_t got, want;
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        got = out_tdata[34:0];
        results_seen++;
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("result with nothing pending: %h", out_tdata));
        end else begin
          want = expected_results.pop_front();
          if (want.reachable) reach_seen++;
          if (got.distance !== want.distance)
            flag_mismatch($sformatf("distance %0d, want %0d", got.distance, want.distance));
          if (got.reachable !== want.reachable)
            flag_mismatch($sformatf("reachable %0b, want %0b", got.reachable,
                                    want.reachable));
          if (got.status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // all requests accepted and all results back, then a short settle
  task automatic wait_drained();
    while (request_queue.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // apb write, register captured at the access edge
  task automatic write_node_count(int value);
    wait_drained();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'd0;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    node_cnt = value[10:0];
    @(posedge clk);
  endtask

  task automatic push(logic [1:0] op, int a, int b, int w);
    request_queue.insert(request_queue.size(), pack_req(op, a, b, w));
  endtask

  // random traffic on a small graph: mostly well-formed adds and queries
  task automatic random_phase(int nodes, int items);
    int r, a, b, added;
    added = 0;
    write_node_count(nodes);
    push(spde_pkg::OpClear, $urandom_range(1023), $urandom_range(1023),
         $urandom_range(65535));
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      a = $urandom_range(nodes - 1);
      b = $urandom_range(nodes - 1);
      if (r < 50 && added < 2 * nodes) begin
        push(spde_pkg::OpAdd, a, b, ($urandom_range(3) == 0) ? 16'hffff - $urandom_range(3)
                                                             : $urandom_range(65535));
        added++;
      end else if (r < 75) begin
        push(spde_pkg::OpQuery, a, ($urandom_range(9) == 0) ? a : b, $urandom_range(65535));
      end else if (r < 86) begin
        push(($urandom_range(1) == 1) ? spde_pkg::OpQuery : spde_pkg::OpAdd,
             $urandom_range(1023), $urandom_range(1023), $urandom_range(65535));
      end else if (r < 93) begin
        push(2'd3, $urandom_range(1023), $urandom_range(1023), $urandom_range(65535));
      end else if (r < 96) begin
        push(spde_pkg::OpClear, a, b, $urandom_range(65535));
        added = 0;
      end else begin
        push(spde_pkg::OpAdd, a, b, $urandom_range(65535));
      end
      // one mid-phase hold until the engine has answered everything
      if (i == items / 2 && nodes == 16) wait_drained();
    end
  endtask

  initial begin
    int modes [4][2];
    int sizes [8];
    modes = '{'{0, 0}, '{66, 0}, '{0, 66}, '{22, 22}};
    sizes = '{8, 16, 3, 24, 12, 5, 20, 10};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full node range at reset size, field extremes, every op
    push(spde_pkg::OpAdd, 0, 1023, 16'hffff);
    push(spde_pkg::OpAdd, 1023, 5, 0);
    push(spde_pkg::OpAdd, 5, 5, 1);
    push(spde_pkg::OpQuery, 0, 5, 0);
    push(spde_pkg::OpQuery, 0, 0, 16'hffff);
    push(spde_pkg::OpQuery, 1023, 2, 0);
    push(spde_pkg::OpQuery, 5, 1023, 0);
    push(2'd3, 1023, 1023, 16'hffff);
    push(spde_pkg::OpAdd, 3, 4, 7);
    push(spde_pkg::OpAdd, 4, 6, 9);
    push(spde_pkg::OpQuery, 3, 6, 0);
    // shrink: edges past the node count stay stored but are skipped
    write_node_count(6);
    push(spde_pkg::OpQuery, 0, 5, 0);
    push(spde_pkg::OpQuery, 3, 4, 0);
    push(spde_pkg::OpQuery, 0, 1023, 0);
    push(spde_pkg::OpAdd, 6, 1, 1);
    write_node_count(1024);
    push(spde_pkg::OpQuery, 3, 6, 0);
    // zero node count: every node out of range
    write_node_count(0);
    push(spde_pkg::OpAdd, 0, 0, 1);
    push(spde_pkg::OpQuery, 0, 0, 0);
    push(spde_pkg::OpClear, 0, 0, 0);
    // single node graph
    write_node_count(1);
    push(spde_pkg::OpAdd, 0, 0, 5);
    push(spde_pkg::OpQuery, 0, 0, 0);
    push(spde_pkg::OpQuery, 0, 1, 0);
    // register top value clamps to the node limit
    write_node_count(2047);
    push(spde_pkg::OpClear, 0, 0, 0);
    push(spde_pkg::OpAdd, 1023, 512, 100);
    push(spde_pkg::OpAdd, 512, 0, 200);
    push(spde_pkg::OpQuery, 1023, 0, 0);

    // tiny graph with an out-of-range add and a clear between queries
    write_node_count(4);
    push(spde_pkg::OpClear, 0, 0, 0);
    push(spde_pkg::OpAdd, 1, 2, 3);
    push(spde_pkg::OpAdd, 9, 2, 3);
    push(spde_pkg::OpQuery, 0, 3, 0);
    push(spde_pkg::OpQuery, 2, 1, 0);
    push(spde_pkg::OpClear, 0, 0, 0);
    push(spde_pkg::OpAdd, 0, 3, 4);
    push(spde_pkg::OpQuery, 0, 3, 0);

    // random phases across sizes and idle patterns
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      send_idle_pct = modes[p % 4][0];
      recv_stall_pct = modes[p % 4][1];
      random_phase(sizes[p], 190);
    end

    wait_drained();
    $display("%0d requests and %0d results over node counts 0 to 2047, %0d reachable",
             requests_sent, results_seen, reach_seen);
    $display("covered shrunk graph, range errors, idle sender and stalled receiver");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
hdl/spde_pkg.sv
hdl/spde_ctrl.sv
hdl/spde_dpath.sv
hdl/shortest_path_distance_engine.sv
verif/shortest_path_distance_engine_tb.sv
